/* hw/rtl/sitda_pkg.sv */
// Shared types, constants and the power-of-ten table for the signed integer
// to decimal ASCII converter. No dependencies.
package sitda_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAG_WIDTH   = 32;
    localparam int WIDE_WIDTH  = 34;
    localparam int POS_WIDTH   = 16;
    localparam int CHAR_WIDTH  = 8;
    localparam int DIG_WIDTH   = 4;
    localparam int MAX_DIGITS  = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = 1;
    localparam int QCNT_WIDTH  = 2;

    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic                 negative;
        logic [MAG_WIDTH-1:0] mag;
        logic [DIG_WIDTH-1:0] ndig;
    } conv_entry_t;

    typedef struct packed {
        logic        valid;
        conv_entry_t entry;
    } conv_slot_t;

    function automatic logic [WIDE_WIDTH-1:0] pow10(input logic [DIG_WIDTH-1:0] p);
        logic [WIDE_WIDTH-1:0] r;
        case (p)
            4'd0:    r = 34'd1;
            4'd1:    r = 34'd10;
            4'd2:    r = 34'd100;
            4'd3:    r = 34'd1000;
            4'd4:    r = 34'd10000;
            4'd5:    r = 34'd100000;
            4'd6:    r = 34'd1000000;
            4'd7:    r = 34'd10000000;
            4'd8:    r = 34'd100000000;
            4'd9:    r = 34'd1000000000;
            default: r = 34'd1;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/signed_int_to_decimal_ascii.sv */
// Signed 32-bit integer to decimal ASCII text, one character per transaction.
// An accepted value passes through the queue and then the output register before its sign
// character appears on the output. The digit emitter produces one character per cycle while
// the output is not stalled; a two-entry queue decouples the input side.
// Reset (rst_n, asynchronous, active low) clears the queue, the emitter state,
// the output valid and the running position counter to zero.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   value_valid,
    output logic                   value_stall,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   char_valid,
    input  logic                   char_stall,
    output logic [CHAR_WIDTH-1:0]  out_char,
    output logic [POS_WIDTH-1:0]   position,
    output logic                   last
);

    conv_slot_t push;
    conv_slot_t head;
    logic       full;
    logic       pop;

    sitda_front u_front (
        .value_valid (value_valid),
        .value       (value),
        .push        (push)
    );

    sitda_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .pop   (pop),
        .head  (head)
    );

    sitda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .out_char   (out_char),
        .position   (position),
        .last       (last)
    );

    assign value_stall = full;

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (out_char == CH_PLUS) || (out_char == CH_MINUS)
                       || ((out_char >= CH_ZERO) && (out_char <= CH_NINE)))
        else $error("output character outside sign and digit set");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && ((out_char == CH_PLUS) || (out_char == CH_MINUS)) |-> !last)
        else $error("sign character flagged as last");

    a_pop_only_when_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("emitter pops an empty queue");

endmodule

/* hw/rtl/sitda_front.sv */
// Front end: takes each value, splits sign and magnitude and counts digits, at least two.
// Depends on sitda_pkg.
module sitda_front
    import sitda_pkg::*;
(
    input  logic                   value_valid,
    input  logic [VALUE_WIDTH-1:0] value,
    output conv_slot_t             push
);

    logic                  negative;
    logic [MAG_WIDTH-1:0]  mag;
    logic [WIDE_WIDTH-1:0] mag_wide;
    logic [DIG_WIDTH-1:0]  ndig;

    always_comb
    begin
        negative = value[VALUE_WIDTH-1];
        mag      = negative ? (~value + 32'd1) : value;
        mag_wide = {{(WIDE_WIDTH-MAG_WIDTH){1'b0}}, mag};
        ndig     = 4'd2;
        for (int p = 2; p < MAX_DIGITS; p++)
        begin
            if (mag_wide >= pow10(DIG_WIDTH'(p)))
            begin
                ndig = DIG_WIDTH'(p + 1);
            end
        end
        push.valid          = value_valid;
        push.entry.negative = negative;
        push.entry.mag      = mag;
        push.entry.ndig     = ndig;
    end

endmodule

/* hw/rtl/sitda_queue.sv */
// Two-entry queue between the classifying front end and the digit emitter.
// Depends on sitda_pkg.
module sitda_queue
    import sitda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  conv_slot_t push,
    output logic       full,
    input  logic       pop,
    output conv_slot_t head
);

    conv_entry_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_WIDTH-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    always_comb
    begin
        full        = (count_reg == QCNT_WIDTH'(QUEUE_DEPTH));
        do_push     = push.valid && !full;
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
        head.valid = (count_reg != '0);
        head.entry = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

/* hw/rtl/sitda_back.sv */
// Back end: emits the sign, then one decimal digit per cycle unless the output
// stalls, most significant first, into the output register. Depends on sitda_pkg.
module sitda_back
    import sitda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  conv_slot_t            head,
    output logic                  pop,
    output logic                  char_valid,
    input  logic                  char_stall,
    output logic [CHAR_WIDTH-1:0] out_char,
    output logic [POS_WIDTH-1:0]  position,
    output logic                  last
);

    typedef enum logic [1:0] {
        ST_SIGN  = 2'b01,
        ST_DIGIT = 2'b10
    } back_state_t;

    back_state_t           state_reg, state_next;
    logic [MAG_WIDTH-1:0]  mag_reg, mag_next;
    logic [DIG_WIDTH-1:0]  p_reg, p_next;
    logic [POS_WIDTH-1:0]  pos_reg, pos_next;
    logic                  valid_reg, valid_next;
    logic [CHAR_WIDTH-1:0] char_reg, char_next;
    logic [POS_WIDTH-1:0]  position_reg, position_next;
    logic                  last_reg, last_next;

    logic                  advance;
    logic [WIDE_WIDTH-1:0] pow;
    logic [WIDE_WIDTH-1:0] mag_wide;
    logic [WIDE_WIDTH-1:0] thr;
    logic [WIDE_WIDTH-1:0] sub;
    logic [WIDE_WIDTH-1:0] diff;
    logic [DIG_WIDTH-1:0]  digit;

    always_comb
    begin
        pow      = pow10(p_reg);
        mag_wide = {{(WIDE_WIDTH-MAG_WIDTH){1'b0}}, mag_reg};
        digit    = '0;
        sub      = '0;
        for (int d = 1; d < 10; d++)
        begin
            thr = WIDE_WIDTH'(pow * WIDE_WIDTH'(d));
            if (mag_wide >= thr)
            begin
                digit = DIG_WIDTH'(d);
                sub   = thr;
            end
        end
        diff = mag_wide - sub;
    end

    always_comb
    begin
        advance       = !valid_reg || !char_stall;
        state_next    = state_reg;
        mag_next      = mag_reg;
        p_next        = p_reg;
        pos_next      = pos_reg;
        valid_next    = valid_reg && char_stall;
        char_next     = char_reg;
        position_next = position_reg;
        last_next     = last_reg;
        pop           = 1'b0;
        case (state_reg)
            ST_SIGN:
            begin
                if (advance && head.valid)
                begin
                    pop           = 1'b1;
                    valid_next    = 1'b1;
                    char_next     = head.entry.negative ? CH_MINUS : CH_PLUS;
                    position_next = pos_reg;
                    last_next     = 1'b0;
                    pos_next      = pos_reg + 1'b1;
                    mag_next      = head.entry.mag;
                    p_next        = head.entry.ndig - 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (advance)
                begin
                    valid_next    = 1'b1;
                    char_next     = CH_ZERO + CHAR_WIDTH'(digit);
                    position_next = pos_reg;
                    last_next     = (p_reg == '0);
                    pos_next      = pos_reg + 1'b1;
                    mag_next      = diff[MAG_WIDTH-1:0];
                    p_next        = p_reg - 1'b1;
                    if (p_reg == '0)
                    begin
                        state_next = ST_SIGN;
                    end
                end
            end
            default:
            begin
                state_next = ST_SIGN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SIGN;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        p_reg        <= p_next;
        char_reg     <= char_next;
        position_reg <= position_next;
        last_reg     <= last_next;
    end

    assign char_valid = valid_reg;
    assign out_char   = char_reg;
    assign position   = position_reg;
    assign last       = last_reg;

endmodule

/* tb/sv/signed_int_to_decimal_ascii_test.sv */
// Testbench for signed_int_to_decimal_ascii: drives signed values with random gaps and
// output stalls, predicts the decimal text per value and checks every character.
// Depends on sitda_pkg and the signed_int_to_decimal_ascii RTL.
module signed_int_to_decimal_ascii_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sitda_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_ITEMS = 260;
    localparam int DIRECTED_N   = 21;

    localparam logic [VALUE_WIDTH-1:0] DIRECTED_VALUES [DIRECTED_N] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'hFFFF_FFF7, 32'd10, 32'hFFFF_FFF6,
        32'd99, 32'd100, 32'hFFFF_FF9C, 32'd1000, 32'd999_999_999,
        32'd1_000_000_000, 32'hC465_3600, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h8000_0001, 32'd123_456_789, 32'h5555_5555, 32'hAAAA_AAAA, 32'd5
    };

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] ch;
        logic [POS_WIDTH-1:0]  pos;
        logic                  last;
    } text_char_t;

    class decimal_text_scoreboard;
        text_char_t           expected_chars[$];
        bit [POS_WIDTH-1:0]   next_position;
        int                   failures;

        function new();
            next_position   = '0;
            failures        = 0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void note_value(input logic [VALUE_WIDTH-1:0] v);
            logic                   negative;
            logic [VALUE_WIDTH-1:0] mag;
            int unsigned            digit_list[$];
            text_char_t             item;
            negative = v[VALUE_WIDTH-1];
            mag      = negative ? (~v + 1'b1) : v;
            do
            begin
                digit_list.push_back(mag % 10);
                mag = mag / 10;
            end
            while (mag != '0);
            if (digit_list.size() == 1)
                digit_list.push_back(0);
            item.ch   = negative ? CH_MINUS : CH_PLUS;
            item.pos  = next_position;
            item.last = 1'b0;
            expected_chars.push_back(item);
            next_position++;
            for (int i = digit_list.size() - 1; i >= 0; i--)
            begin
                item.ch   = CH_ZERO + CHAR_WIDTH'(digit_list[i]);
                item.pos  = next_position;
                item.last = (i == 0);
                expected_chars.push_back(item);
                next_position++;
            end
        endfunction

        function void check_char(input logic [CHAR_WIDTH-1:0] ch,
                                 input logic [POS_WIDTH-1:0] pos, input logic lst);
            text_char_t want;
            if (expected_chars.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected char %h at position %0d, last %b", ch, pos, lst);
                return;
            end
            want = expected_chars.pop_front();
            if (ch !== want.ch || pos !== want.pos || lst !== want.last)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: expected %h pos %0d last %b, got %h pos %0d last %b",
                             want.ch, want.pos, want.last, ch, pos, lst);
            end
        endfunction

        function void report_leftover();
            if (expected_chars.size() != 0)
            begin
                failures++;
                $display("%0d expected chars never arrived", expected_chars.size());
            end
        endfunction
    endclass

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   value_valid = 1'b0;
    logic [VALUE_WIDTH-1:0] value       = '0;
    logic                   char_stall  = 1'b0;
    logic                   value_stall;
    logic                   char_valid;
    logic [CHAR_WIDTH-1:0]  out_char;
    logic [POS_WIDTH-1:0]   position;
    logic                   last;

    bit                     calm        = 1'b0;
    int unsigned            cycle_count = 0;

    decimal_text_scoreboard board = new();

    signed_int_to_decimal_ascii u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .out_char    (out_char),
        .position    (position),
        .last        (last)
    );

    always
    begin
        #(HALF_PERIOD) clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] random_value();
        int                     kind;
        int                     ex;
        logic [VALUE_WIDTH-1:0] p;
        logic [VALUE_WIDTH-1:0] v;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2:
                v = $urandom();
            3:
                v = $urandom_range(0, 40) - 20;
            4:
            begin
                ex = $urandom_range(0, 9);
                p  = 1;
                repeat (ex) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1))
                    v = ~v + 1'b1;
            end
            5:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h8000_0001;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = '0;
                endcase
            end
            default:
            begin
                ex = $urandom_range(1, 9);
                p  = 1;
                repeat (ex) p = p * 10;
                v = $urandom() % p;
                if ($urandom_range(0, 1))
                    v = ~v + 1'b1;
            end
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            value_valid = 1'b0;
        end
        @(negedge clk);
        value_valid = 1'b1;
        value       = v;
        @(posedge clk);
        while (value_stall)
            @(posedge clk);
        board.note_value(v);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        value_valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stall_driver
        int stall_len;
        int open_len;
        forever
        begin
            stall_len = pick_gap();
            repeat (stall_len)
            begin
                @(negedge clk);
                char_stall = 1'b1;
            end
            open_len = $urandom_range(1, 8);
            repeat (open_len)
            begin
                @(negedge clk);
                char_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && char_valid && !char_stall)
            board.check_char(out_char, position, last);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
            send_value(DIRECTED_VALUES[i]);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS / 2; i++)
            send_value(random_value());
        wait_drained();

        // hold both sides busy, no idling
        calm = 1'b1;
        for (int i = 0; i < 40; i++)
            send_value(random_value());
        calm = 1'b0;

        for (int i = 0; i < RANDOM_ITEMS / 2 - 40; i++)
            send_value(random_value());

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        board.report_leftover();
        if (board.failures == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_front.sv
hw/rtl/sitda_queue.sv
hw/rtl/sitda_back.sv
hw/rtl/signed_int_to_decimal_ascii.sv
tb/sv/signed_int_to_decimal_ascii_test.sv
